// ===== hw/rtl/ssrs_pkg.sv =====
// Shared constants, command type and helpers for the suffixient set run scanner.
// No dependencies; every other file of the block imports this package.
package ssrs_pkg;

    // Alphabet of dense symbol codes; code 0 is the separator.
    localparam int ALPHABET      = 32;
    localparam int ALPH_IDX_BITS = $clog2(ALPHABET);

    // Fixed field widths of the channels.
    localparam int SYM_BITS = 5;
    localparam int LCP_BITS = 48;
    localparam int SA_BITS  = 48;

    // Width of stored and emitted positions; arithmetic wraps at this width.
    localparam int POS_BITS = 48;

    // Candidate lengths are kept as length plus one, so that minus one is code zero.
    localparam int LEN_BITS = LCP_BITS + 1;
    localparam logic [LEN_BITS-1:0] LCP_INF = {1'b1, {LCP_BITS{1'b0}}};
    localparam logic [LEN_BITS-1:0] LEN_NONE = '0;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 48;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEXT_LEN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MINUS_ONE = 2'd1;
    localparam logic [SA_BITS-1:0] TEXT_LEN_RESET = SA_BITS'(1);

    // Command queue between the front and the back.
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef logic [ALPHABET-1:0] sym_vec_t;

    // One classified run, as the back carries it out.
    typedef struct packed {
        logic                change;
        logic                fin;
        logic [SYM_BITS-1:0] prev_sym;
        logic [SYM_BITS-1:0] cur_sym;
        logic [LEN_BITS-1:0] top_code;
        logic [LEN_BITS-1:0] bound_code;
        logic [POS_BITS-1:0] pos_prev;
        logic [POS_BITS-1:0] pos_cur;
    } cmd_t;

    function automatic logic [LEN_BITS-1:0] min_len(
        input logic [LEN_BITS-1:0] a,
        input logic [LEN_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/ssrs_run_if.sv =====
// Input channel of the run scanner: one BWT run per transfer.
// Depends on ssrs_pkg for the field widths.
interface ssrs_run_if;
    import ssrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYM_BITS-1:0] symbol;
    logic [LCP_BITS-1:0] top_lcp;
    logic [LCP_BITS-1:0] interior_min;
    logic                single_row;
    logic [SA_BITS-1:0]  sa_first;
    logic [SA_BITS-1:0]  sa_last;
    logic                final_run;

    modport source (
        output valid, symbol, top_lcp, interior_min, single_row, sa_first, sa_last,
               final_run,
        input  ready
    );

    modport sink (
        input  valid, symbol, top_lcp, interior_min, single_row, sa_first, sa_last,
               final_run,
        output ready
    );

endinterface

// ===== hw/rtl/ssrs_result_if.sv =====
// Output channel of the run scanner: one emitted position per transfer.
// Depends on ssrs_pkg for the field widths.
interface ssrs_result_if;
    import ssrs_pkg::*;

    logic               valid;
    logic               ready;
    logic [SA_BITS-1:0] position;
    logic               last_of_burst;

    modport source (
        output valid, position, last_of_burst,
        input  ready
    );

    modport sink (
        input  valid, position, last_of_burst,
        output ready
    );

endinterface

// ===== hw/rtl/ssrs_cmd_queue.sv =====
// Short command queue between the front classifier and the back executor.
// Depends on ssrs_pkg for cmd_t and the queue depth.
module ssrs_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ssrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output ssrs_pkg::cmd_t head,
    output logic           empty
);
    import ssrs_pkg::*;

    cmd_t                 slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QCNT_BITS'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                                                                : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0
                                                                : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/ssrs_front.sv =====
// Front of the run scanner: accepts runs, tracks the run boundary minimum and
// classifies each run into a command for the back. Depends on ssrs_pkg.
module ssrs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    ssrs_run_if.sink                     run,
    input  logic [ssrs_pkg::SA_BITS-1:0] text_len,
    input  logic                         q_full,
    output logic                         q_push,
    output ssrs_pkg::cmd_t               q_cmd
);
    import ssrs_pkg::*;

    logic                seen_reg;
    logic                seen_next;
    logic [SYM_BITS-1:0] prev_sym_reg;
    logic [SYM_BITS-1:0] prev_sym_next;
    logic [SA_BITS-1:0]  prev_sa_reg;
    logic [SA_BITS-1:0]  prev_sa_next;
    logic [LEN_BITS-1:0] prev_imin_reg;
    logic [LEN_BITS-1:0] prev_imin_next;
    logic [LEN_BITS-1:0] run_min_reg;
    logic [LEN_BITS-1:0] run_min_next;

    logic                accept;
    logic [SYM_BITS-1:0] sym;
    logic [LEN_BITS-1:0] top_ext;
    logic [LEN_BITS-1:0] imin;
    logic [LEN_BITS-1:0] mm;
    logic [LEN_BITS-1:0] bound;
    logic                change;
    logic [POS_BITS-1:0] n_pos;

    assign run.ready = !q_full;
    assign accept    = run.valid && run.ready;

    always_comb
    begin
        // Codes outside the alphabet fold onto the separator.
        sym     = (int'(run.symbol) < ALPHABET) ? run.symbol : '0;
        top_ext = {1'b0, run.top_lcp};
        imin    = run.single_row ? LCP_INF : {1'b0, run.interior_min};
        mm      = min_len(run_min_reg, prev_imin_reg);
        bound   = min_len(mm, top_ext);
        change  = seen_reg && (sym != prev_sym_reg);
        n_pos   = POS_BITS'(text_len);

        q_cmd.change     = change;
        q_cmd.fin        = run.final_run;
        q_cmd.prev_sym   = prev_sym_reg;
        q_cmd.cur_sym    = sym;
        q_cmd.top_code   = top_ext + 1'b1;
        q_cmd.bound_code = bound + 1'b1;
        q_cmd.pos_prev   = n_pos - POS_BITS'(prev_sa_reg);
        q_cmd.pos_cur    = n_pos - POS_BITS'(run.sa_first);

        // Non-final runs that continue the same symbol push no command; they only update the front's state.
        q_push = accept && (change || run.final_run);

        seen_next      = seen_reg;
        prev_sym_next  = prev_sym_reg;
        prev_sa_next   = prev_sa_reg;
        prev_imin_next = prev_imin_reg;
        run_min_next   = run_min_reg;
        if (accept)
        begin
            if (run.final_run)
            begin
                seen_next      = 1'b0;
                prev_sym_next  = '0;
                prev_sa_next   = '0;
                prev_imin_next = LCP_INF;
                run_min_next   = LCP_INF;
            end
            else
            begin
                seen_next      = 1'b1;
                prev_sym_next  = sym;
                prev_sa_next   = run.sa_last;
                prev_imin_next = imin;
                run_min_next   = (seen_reg && !change) ? bound : LCP_INF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_sym_reg  <= '0;
            prev_sa_reg   <= '0;
            prev_imin_reg <= LCP_INF;
            run_min_reg   <= LCP_INF;
        end
        else
        begin
            seen_reg      <= seen_next;
            prev_sym_reg  <= prev_sym_next;
            prev_sa_reg   <= prev_sa_next;
            prev_imin_reg <= prev_imin_next;
            run_min_reg   <= run_min_next;
        end
    end

endmodule

// ===== hw/rtl/ssrs_back.sv =====
// Back of the run scanner: holds the per-symbol candidate table, sweeps it,
// serializes emissions into the output register. Depends on ssrs_pkg.
module ssrs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssrs_pkg::cmd_t               q_head,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic                         minus_one,
    ssrs_result_if.source                result
);
    import ssrs_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_EMIT  = 2'd1;
    localparam logic [1:0] B_RAISE = 2'd2;
    localparam logic [1:0] B_FLUSH = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic                flush_phase_reg;
    logic                flush_phase_next;
    logic                fin_reg;
    logic                fin_next;
    logic                flush_will_reg;
    logic                flush_will_next;
    sym_vec_t            pending_reg;
    sym_vec_t            pending_next;
    sym_vec_t            rp_reg;
    sym_vec_t            rp_next;
    sym_vec_t            rc_reg;
    sym_vec_t            rc_next;
    sym_vec_t            active_reg;
    sym_vec_t            active_next;
    logic [LEN_BITS-1:0] top_reg;
    logic [LEN_BITS-1:0] top_next;
    logic [POS_BITS-1:0] pos_prev_reg;
    logic [POS_BITS-1:0] pos_prev_next;
    logic [POS_BITS-1:0] pos_cur_reg;
    logic [POS_BITS-1:0] pos_cur_next;
    logic [LEN_BITS-1:0] len_reg  [ALPHABET];
    logic [LEN_BITS-1:0] len_next [ALPHABET];
    logic [POS_BITS-1:0] pos_reg  [ALPHABET];
    logic [POS_BITS-1:0] pos_next [ALPHABET];
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SA_BITS-1:0]  out_pos_reg;
    logic [SA_BITS-1:0]  out_pos_next;
    logic                out_last_reg;
    logic                out_last_next;

    sym_vec_t               hit;
    sym_vec_t               rp_vec;
    sym_vec_t               rc_vec;
    sym_vec_t               sweep_pend;
    sym_vec_t               after;
    sym_vec_t               pend_rest;
    logic                   rise;
    logic                   flush_will;
    logic [ALPH_IDX_BITS-1:0] emit_idx;
    logic [POS_BITS-1:0]    emit_pos;
    logic [POS_BITS-1:0]    emit_val;
    logic                   out_free;
    logic                   emit_fire;

    assign result.valid         = out_valid_reg;
    assign result.position      = out_pos_reg;
    assign result.last_of_burst = out_last_reg;

    // Parallel classification of the table against the head command.
    always_comb
    begin
        rise = 1'b0;
        for (int c = 0; c < ALPHABET; c++)
        begin
            hit[c] = (c != 0) && (q_head.bound_code < len_reg[c]);
            rise   = hit[c] ? (q_head.top_code > q_head.bound_code)
                            : (q_head.top_code > len_reg[c]);
            rp_vec[c] = (c == int'(q_head.prev_sym)) && rise;
            rc_vec[c] = (c == int'(q_head.cur_sym)) && rise;
        end
        sweep_pend = hit & active_reg;
        after      = (active_reg & ~hit) | rp_vec | rc_vec;
        after[0]   = 1'b0;
        flush_will = q_head.fin && (after != '0);
    end

    // Lowest pending symbol goes out first.
    always_comb
    begin
        emit_idx = '0;
        for (int c = ALPHABET - 1; c >= 0; c--)
        begin
            if (pending_reg[c])
            begin
                emit_idx = ALPH_IDX_BITS'(c);
            end
        end
        emit_pos  = pos_reg[emit_idx];
        emit_val  = minus_one ? (emit_pos - 1'b1) : emit_pos;
        pend_rest = pending_reg & (pending_reg - 1'b1);
        out_free  = !out_valid_reg || result.ready;
    end

    always_comb
    begin
        state_next       = state_reg;
        flush_phase_next = flush_phase_reg;
        fin_next         = fin_reg;
        flush_will_next  = flush_will_reg;
        pending_next     = pending_reg;
        rp_next          = rp_reg;
        rc_next          = rc_reg;
        active_next      = active_reg;
        top_next         = top_reg;
        pos_prev_next    = pos_prev_reg;
        pos_cur_next     = pos_cur_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        q_pop            = 1'b0;
        emit_fire        = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    fin_next = q_head.fin;
                    if (q_head.change)
                    begin
                        // Boundary sweep: every candidate but the separator's that is above the bound drops to it.
                        for (int c = 0; c < ALPHABET; c++)
                        begin
                            if (hit[c])
                            begin
                                len_next[c] = q_head.bound_code;
                            end
                        end
                        active_next      = active_reg & ~hit;
                        pending_next     = sweep_pend;
                        rp_next          = rp_vec;
                        rc_next          = rc_vec;
                        top_next         = q_head.top_code;
                        pos_prev_next    = q_head.pos_prev;
                        pos_cur_next     = q_head.pos_cur;
                        flush_will_next  = flush_will;
                        flush_phase_next = 1'b0;
                        state_next       = (sweep_pend != '0) ? B_EMIT : B_RAISE;
                    end
                    else
                    begin
                        state_next = B_FLUSH;
                    end
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    emit_fire    = 1'b1;
                    pending_next = pend_rest;
                    if (pend_rest == '0)
                    begin
                        state_next = flush_phase_reg ? B_IDLE : B_RAISE;
                    end
                end
            end
            B_RAISE:
            begin
                // Positions are overwritten only after the sweep has read them.
                for (int c = 0; c < ALPHABET; c++)
                begin
                    if (rp_reg[c] || rc_reg[c])
                    begin
                        len_next[c]    = top_reg;
                        active_next[c] = 1'b1;
                        pos_next[c]    = rp_reg[c] ? pos_prev_reg : pos_cur_reg;
                    end
                end
                state_next = fin_reg ? B_FLUSH : B_IDLE;
            end
            B_FLUSH:
            begin
                pending_next     = active_reg;
                pending_next[0]  = 1'b0;
                active_next      = '0;
                flush_phase_next = 1'b1;
                for (int c = 0; c < ALPHABET; c++)
                begin
                    len_next[c] = LEN_NONE;
                end
                state_next = (pending_next != '0) ? B_EMIT : B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = SA_BITS'(emit_val);
            out_last_next  = (pend_rest == '0) && (flush_phase_reg || !flush_will_reg);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            flush_phase_reg <= 1'b0;
            fin_reg         <= 1'b0;
            flush_will_reg  <= 1'b0;
            pending_reg     <= '0;
            rp_reg          <= '0;
            rc_reg          <= '0;
            active_reg      <= '0;
            out_valid_reg   <= 1'b0;
            for (int c = 0; c < ALPHABET; c++)
            begin
                len_reg[c] <= LEN_NONE;
            end
        end
        else
        begin
            state_reg       <= state_next;
            flush_phase_reg <= flush_phase_next;
            fin_reg         <= fin_next;
            flush_will_reg  <= flush_will_next;
            pending_reg     <= pending_next;
            rp_reg          <= rp_next;
            rc_reg          <= rc_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
            len_reg         <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        pos_prev_reg <= pos_prev_next;
        pos_cur_reg  <= pos_cur_next;
        pos_reg      <= pos_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EMIT) |-> (pending_reg != '0))
        else $error("emit state entered with nothing pending");

    a_separator_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg[0])
        else $error("separator candidate scheduled for emission");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FLUSH) |=> (active_reg == '0))
        else $error("flush left active candidates");

    a_raise_targets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RAISE) |-> ($onehot0(rp_reg) && $onehot0(rc_reg)
                                    && ((rp_reg & rc_reg) == '0)))
        else $error("raise touches more than the two neighboring symbols");

endmodule

// ===== hw/rtl/suffixient_set_run_scanner_unit.sv =====
// Top level of the suffixient set run scanner: configuration registers, front,
// command queue and back. Depends on ssrs_pkg and both channel interfaces.
//
// Usage: runs of the BWT enter on the run channel, one per transfer, in BWT
// order; the last run of a text carries final_run. Positions of the
// suffixient set leave on the result channel; last_of_burst marks the final
// position caused by one run. A run that causes nothing produces no transfer.
// Configuration (text length plus one, minus-one convention) is written on the
// plain write port between texts, while the block is idle.
//
// Timing: the front takes a run whenever the two-entry command queue has
// room. In the back, a run that keeps the previous symbol costs nothing; a
// symbol change is popped, swept, emits each swept position and raises the
// candidates, and a final run then adds a flush that emits each active
// position, or goes straight to the flush when it keeps the symbol. The
// sweep over the 32 candidates is a single parallel compare. A run's command
// passes the queue slot and the back's state register before its first
// position reaches the output register; emissions then leave one per cycle
// while the receiver keeps ready high. Reset empties the queue, clears the
// candidate lengths and restores the control and configuration registers.
// When the receiver stalls, the output register holds its transfer, the
// back waits, and once the queue fills the run channel drops ready.
module suffixient_set_run_scanner_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ssrs_run_if.sink                           run,
    ssrs_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [ssrs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ssrs_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
    import ssrs_pkg::*;

    logic [SA_BITS-1:0] text_len_reg;
    logic               minus_one_reg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    // Writes to indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_len_reg  <= TEXT_LEN_RESET;
            minus_one_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEXT_LEN:
                begin
                    text_len_reg <= SA_BITS'(cfg_wdata);
                end
                CFG_MINUS_ONE:
                begin
                    minus_one_reg <= cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The front classifies each run against the previous one.
    ssrs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .run      (run),
        .text_len (text_len_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // The queue lets the front keep taking runs while the back emits.
    ssrs_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // The back owns the candidate table and the output register.
    ssrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .minus_one (minus_one_reg),
        .result    (result)
    );

endmodule
